// File: hdl/pdt_pkg.sv
// ----------------------------------------------------------------------------
// pdt_pkg
// shared types, constants and geometry helpers for the polygon diagonal test
// ----------------------------------------------------------------------------
package pdt_pkg;

  localparam int MaxVertices = 64;
  localparam int CoordBits   = 16;
  localparam int IdxBits     = $clog2(MaxVertices);
  localparam int CntBits     = $clog2(MaxVertices + 1);
  localparam int DiffBits    = CoordBits + 1;
  localparam int ProdBits    = 2 * DiffBits;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  // orientation codes
  localparam logic [1:0] OrientLeft  = 2'b01;
  localparam logic [1:0] OrientOn    = 2'b00;
  localparam logic [1:0] OrientRight = 2'b11;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // datapath operand select codes for the six neighbor reads
  typedef enum logic [2:0] {
    SelA0 = 3'd0,
    SelA  = 3'd1,
    SelA1 = 3'd2,
    SelB0 = 3'd3,
    SelB  = 3'd4,
    SelB1 = 3'd5
  } sel_e;

  // controller to datapath
  typedef struct packed {
    logic               write_en;
    logic [IdxBits-1:0] rd_addr;
    logic               rd_en;
    logic               load_pt;
    sel_e               load_sel;
    logic               load_edge;   // shift read data into edge pipeline
    logic               cone_eval;
    logic               edge_eval;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic result;
  } stat_t;

  // sign of doubled triangle area: left, collinear or right
  function automatic logic [1:0] orient(pt_t a, pt_t b, pt_t c);
    logic signed [DiffBits-1:0] bx, by, cx, cy;
    logic signed [ProdBits-1:0] p1, p2;
    bx = DiffBits'(b.x) - DiffBits'(a.x);
    by = DiffBits'(b.y) - DiffBits'(a.y);
    cx = DiffBits'(c.x) - DiffBits'(a.x);
    cy = DiffBits'(c.y) - DiffBits'(a.y);
    p1 = bx * cy;
    p2 = cx * by;
    if (p1 > p2) return OrientLeft;
    else if (p1 < p2) return OrientRight;
    else return OrientOn;
  endfunction

  function automatic logic left_of(pt_t a, pt_t b, pt_t c);
    return orient(a, b, c) == OrientLeft;
  endfunction

  function automatic logic left_on(pt_t a, pt_t b, pt_t c);
    return orient(a, b, c) != OrientRight;
  endfunction

  function automatic logic in_cone(pt_t p, pt_t v, pt_t n, pt_t o);
    if (left_on(v, n, p)) return left_of(v, o, p) && left_of(o, v, n);
    else return !(left_on(v, o, n) && left_on(o, v, p));
  endfunction

endpackage

// File: hdl/pdt_ctrl.sv
// ----------------------------------------------------------------------------
// pdt_ctrl
// sequencer: handshakes, range checks, neighbor reads and edge walk
// ----------------------------------------------------------------------------
module pdt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [pdt_pkg::IdxBits-1:0]   first_index_i,
  input  logic [pdt_pkg::IdxBits-1:0]   second_index_i,
  input  logic [pdt_pkg::CntBits-1:0]   vertex_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_diagonal_o,
  output logic                          status_o,
  output pdt_pkg::cmd_t                 cmd_o,
  input  pdt_pkg::stat_t                stat_i
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StRead  = 6'b000010,
    StCone  = 6'b000100,
    StWalk  = 6'b001000,
    StDrain = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  localparam int IB = pdt_pkg::IdxBits;

  state_e state_q, state_d;
  logic [IB-1:0] i_q, j_q, last_q, ptr_q, ptr_d;
  logic [2:0] rd_cnt_q, rd_cnt_d;
  logic [1:0] drain_q, drain_d;
  logic       first_q, first_d;
  logic       diag_q, diag_d, stat_q, stat_d, ov_q, ov_d;
  logic       accept, bad;
  logic [IB-1:0] i_prev, i_next, j_prev, j_next;
  pdt_pkg::sel_e sel_lag_q;
  logic       rd_lag_v_q;
  logic       walk_v_q, walk_first_q;

  assign in_stall_o = (state_q != StIdle) || (ov_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign bad = (vertex_count_i < pdt_pkg::CntBits'(3)) ||
               (vertex_count_i > pdt_pkg::CntBits'(pdt_pkg::MaxVertices)) ||
               (pdt_pkg::CntBits'(first_index_i) >= vertex_count_i) ||
               (pdt_pkg::CntBits'(second_index_i) >= vertex_count_i);

  assign i_prev = (i_q == '0) ? last_q : i_q - IB'(1);
  assign i_next = (i_q == last_q) ? '0 : i_q + IB'(1);
  assign j_prev = (j_q == '0) ? last_q : j_q - IB'(1);
  assign j_next = (j_q == last_q) ? '0 : j_q + IB'(1);

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    rd_cnt_d = rd_cnt_q;
    drain_d  = drain_q;
    first_d  = first_q;
    diag_d   = diag_q;
    stat_d   = stat_q;
    ov_d     = ov_q && out_stall_i;
    cmd_o    = '0;
    cmd_o.load_sel = pdt_pkg::SelA;
    cmd_o.rd_addr  = ptr_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (op_i == pdt_pkg::OpWrite) begin
            cmd_o.write_en = 1'b1;
          end else if (bad) begin
            diag_d = 1'b0;
            stat_d = 1'b1;
            ov_d   = 1'b1;
          end else begin
            rd_cnt_d = '0;
            state_d  = StRead;
          end
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        unique case (rd_cnt_q)
          3'd0:    cmd_o.rd_addr = i_prev;
          3'd1:    cmd_o.rd_addr = i_q;
          3'd2:    cmd_o.rd_addr = i_next;
          3'd3:    cmd_o.rd_addr = j_prev;
          3'd4:    cmd_o.rd_addr = j_q;
          default: cmd_o.rd_addr = j_next;
        endcase
        rd_cnt_d = rd_cnt_q + 3'd1;
        if (rd_cnt_q == 3'd5) state_d = StCone;
      end
      StCone: begin
        // last neighbor lands this cycle; evaluate cones next cycle
        ptr_d   = '0;
        first_d = 1'b1;
        state_d = StWalk;
      end
      StWalk: begin
        // walk vertices 0..last then wrap to 0 to close the final edge
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = ptr_q;
        first_d       = 1'b0;
        if (first_q) cmd_o.cone_eval = 1'b1;
        if (!first_q && ptr_q == '0) begin
          drain_d = 2'd0;
          state_d = StDrain;
        end else begin
          ptr_d = (ptr_q == last_q) ? '0 : ptr_q + IB'(1);
        end
      end
      StDrain: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == 2'd2) begin
          diag_d  = stat_i.result;
          stat_d  = 1'b0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!(ov_q && out_stall_i)) begin
          ov_d    = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    // read data arrives in the cycle after the address
    cmd_o.load_pt    = rd_lag_v_q;
    cmd_o.load_sel   = sel_lag_q;
    cmd_o.load_edge  = walk_v_q;
    cmd_o.edge_eval  = walk_v_q && !walk_first_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ov_q         <= 1'b0;
      rd_lag_v_q   <= 1'b0;
      walk_v_q     <= 1'b0;
      walk_first_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      ov_q         <= ov_d;
      rd_lag_v_q   <= (state_q == StRead);
      walk_v_q     <= (state_q == StWalk);
      walk_first_q <= (state_q == StWalk) && first_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      i_q    <= first_index_i;
      j_q    <= second_index_i;
      last_q <= IB'(vertex_count_i - pdt_pkg::CntBits'(1));
    end
    ptr_q     <= ptr_d;
    rd_cnt_q  <= rd_cnt_d;
    drain_q   <= drain_d;
    first_q   <= first_d;
    diag_q    <= diag_d;
    stat_q    <= stat_d;
    sel_lag_q <= pdt_pkg::sel_e'(rd_cnt_q);
  end

  assign out_valid_o   = ov_q;
  assign is_diagonal_o = diag_q;
  assign status_o      = stat_q;

endmodule

// File: hdl/pdt_dp.sv
// ----------------------------------------------------------------------------
// pdt_dp
// vertex memory, endpoint registers, cone and edge crossing tests
// ----------------------------------------------------------------------------
module pdt_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pdt_pkg::cmd_t                        cmd_i,
  input  logic [pdt_pkg::IdxBits-1:0]          wr_addr_i,
  input  logic signed [pdt_pkg::CoordBits-1:0] vertex_x_i,
  input  logic signed [pdt_pkg::CoordBits-1:0] vertex_y_i,
  output pdt_pkg::stat_t                       stat_o
);

  pdt_pkg::pt_t mem [pdt_pkg::MaxVertices];
  pdt_pkg::pt_t rd_q;
  pdt_pkg::pt_t a0_q, a_q, a1_q, b0_q, b_q, b1_q;
  pdt_pkg::pt_t c_q, c1_q;
  logic         edge_v_q;
  logic         ok_q;
  logic         meet;
  logic [1:0]   o_abc, o_abd, o_cda, o_cdb;
  logic         hit;

  function automatic logic on_seg(pdt_pkg::pt_t a, pdt_pkg::pt_t b, pdt_pkg::pt_t c);
    if (a.x != b.x)
      return (a.x <= c.x && c.x <= b.x) || (a.x >= c.x && c.x >= b.x);
    return (a.y <= c.y && c.y <= b.y) || (a.y >= c.y && c.y >= b.y);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en) begin
      mem[wr_addr_i] <= '{x: pdt_pkg::coord_t'(vertex_x_i),
                          y: pdt_pkg::coord_t'(vertex_y_i)};
    end
    if (cmd_i.rd_en) rd_q <= mem[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      unique case (cmd_i.load_sel)
        pdt_pkg::SelA0: a0_q <= rd_q;
        pdt_pkg::SelA:  a_q  <= rd_q;
        pdt_pkg::SelA1: a1_q <= rd_q;
        pdt_pkg::SelB0: b0_q <= rd_q;
        pdt_pkg::SelB:  b_q  <= rd_q;
        default:        b1_q <= rd_q;
      endcase
    end
    if (cmd_i.load_edge) begin
      c_q  <= c1_q;
      c1_q <= rd_q;
    end
  end

  // edge under test is c_q..c1_q, registered in the cycle after load
  always_comb begin
    o_abc = pdt_pkg::orient(a_q, b_q, c_q);
    o_abd = pdt_pkg::orient(a_q, b_q, c1_q);
    o_cda = pdt_pkg::orient(c_q, c1_q, a_q);
    o_cdb = pdt_pkg::orient(c_q, c1_q, b_q);
    meet  = 1'b0;
    if (o_abc != pdt_pkg::OrientOn && o_abd != pdt_pkg::OrientOn &&
        o_cda != pdt_pkg::OrientOn && o_cdb != pdt_pkg::OrientOn)
      meet = (o_abc != o_abd) && (o_cda != o_cdb);
    if (o_abc == pdt_pkg::OrientOn && on_seg(a_q, b_q, c_q))  meet = 1'b1;
    if (o_abd == pdt_pkg::OrientOn && on_seg(a_q, b_q, c1_q)) meet = 1'b1;
    if (o_cda == pdt_pkg::OrientOn && on_seg(c_q, c1_q, a_q)) meet = 1'b1;
    if (o_cdb == pdt_pkg::OrientOn && on_seg(c_q, c1_q, b_q)) meet = 1'b1;
    hit = meet && (c_q != a_q) && (c1_q != a_q) && (c_q != b_q) && (c1_q != b_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_v_q <= 1'b0;
      ok_q     <= 1'b0;
    end else begin
      edge_v_q <= cmd_i.edge_eval;
      if (cmd_i.cone_eval) begin
        ok_q <= pdt_pkg::in_cone(a0_q, a_q, a1_q, b_q) &&
                pdt_pkg::in_cone(b0_q, b_q, b1_q, a_q);
      end else if (edge_v_q && hit) begin
        ok_q <= 1'b0;
      end
    end
  end

  assign stat_o.result = ok_q;

endmodule

// File: hdl/polygon_diagonal_test.sv
// ----------------------------------------------------------------------------
// polygon_diagonal_test
// ear-clipping diagonal test over a stored polygon
// ----------------------------------------------------------------------------
// A write item stores one vertex and produces no result. A query item reads
// six neighbor vertices, evaluates both cones, then walks every polygon edge
// through the single memory read port, one edge per cycle. A bad count or
// index answers with status 1 in the cycle after the item. Vertices must be
// written before a query reads them.
module polygon_diagonal_test (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 op_i,
  input  logic [pdt_pkg::IdxBits-1:0]          first_index_i,
  input  logic [pdt_pkg::IdxBits-1:0]          second_index_i,
  input  logic signed [pdt_pkg::CoordBits-1:0] vertex_x_i,
  input  logic signed [pdt_pkg::CoordBits-1:0] vertex_y_i,
  input  logic [pdt_pkg::CntBits-1:0]          vertex_count_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 is_diagonal_o,
  output logic                                 status_o
);

  pdt_pkg::cmd_t  cmd;
  pdt_pkg::stat_t stat;

  // sequencer
  pdt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i,
    .first_index_i, .second_index_i, .vertex_count_i,
    .out_valid_o, .out_stall_i, .is_diagonal_o, .status_o,
    .cmd_o(cmd), .stat_i(stat)
  );

  // vertex memory and geometry tests
  pdt_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .wr_addr_i(first_index_i),
    .vertex_x_i, .vertex_y_i, .stat_o(stat)
  );

endmodule
